[rtl/hdma_pkg.sv]
package hdma_pkg;

	// Input function codes.
	localparam logic [2:0] FN_READ  = 3'd0;
	localparam logic [2:0] FN_WRITE = 3'd1;
	localparam logic [2:0] FN_DMAEN = 3'd2;
	localparam logic [2:0] FN_HDMEN = 3'd3;
	localparam logic [2:0] FN_INIT  = 3'd4;
	localparam logic [2:0] FN_LINE  = 3'd5;
	localparam logic [2:0] FN_TICK  = 3'd6;
	localparam logic [2:0] FN_FETCH = 3'd7;

	// Result kinds.
	localparam logic [2:0] K_READ  = 3'd0;
	localparam logic [2:0] K_A2B   = 3'd1;
	localparam logic [2:0] K_B2A   = 3'd2;
	localparam logic [2:0] K_FETCH = 3'd3;
	localparam logic [2:0] K_DONE  = 3'd4;

	// Sequencer modes and fetch waits.
	localparam logic [1:0] SM_IDLE = 2'd0;
	localparam logic [1:0] SM_INIT = 2'd1;
	localparam logic [1:0] SM_LINE = 2'd2;
	localparam logic [1:0] W_NONE = 2'd0;
	localparam logic [1:0] W_REP  = 2'd1;
	localparam logic [1:0] W_LO   = 2'd2;
	localparam logic [1:0] W_HI   = 2'd3;

	localparam logic [9:0] HDMA_MAX = 10'd1023;
	localparam logic [5:0] DMA_MAX  = 6'd63;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE, OP_READ, OP_WRITE, OP_DMAEN, OP_HDMEN, OP_START, OP_WALK,
		OP_XFER, OP_FDATA, OP_TICK, OP_DONE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] func;
		logic [6:0] ra;
		logic [7:0] wd;
	} dp_cmd_t;

	typedef struct packed {
		logic walking; // walk still in progress
		logic xfer;    // HDMA copies pending on current channel
		logic emit;    // result emitted this cycle
	} dp_stat_t;

	function automatic logic [7:0] boff(input logic [2:0] m, input logic [1:0] j);
		logic [7:0] v;
		v = 8'd0;
		unique case (m)
			3'd1, 3'd5: v = {7'd0, j[0]};
			3'd3, 3'd7: v = {7'd0, j[1]};
			3'd4:       v = {6'd0, j};
			default:    v = 8'd0;
		endcase
		return v;
	endfunction

	function automatic logic [2:0] xlen_m1(input logic [2:0] m);
		logic [2:0] v;
		unique case (m)
			3'd0:             v = 3'd0;
			3'd1, 3'd2, 3'd6: v = 3'd1;
			default:          v = 3'd3;
		endcase
		return v;
	endfunction

endpackage

[rtl/hdma_ctrl.sv]
module hdma_ctrl
	import hdma_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] func,
	input  logic [6:0] reg_addr,
	input  logic [7:0] wdata,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd,
	output logic       busy
);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WALK, S_XFER} state_t;
	state_t state_q;
	logic [2:0] func_q;
	logic [6:0] ra_q;
	logic [7:0] wd_q;

	assign busy = (state_q != S_IDLE);

	// Command to the datapath from the current state.
	always_comb begin
		cmd.func = func_q;
		cmd.ra   = ra_q;
		cmd.wd   = wd_q;
		cmd.op   = OP_NONE;
		unique case (state_q)
			S_IDLE: cmd.op = OP_NONE;
			S_EXEC: begin
				unique case (func_q)
					FN_READ:  cmd.op = OP_READ;
					FN_WRITE: cmd.op = OP_WRITE;
					FN_DMAEN: cmd.op = OP_DMAEN;
					FN_HDMEN: cmd.op = OP_HDMEN;
					FN_INIT, FN_LINE: cmd.op = OP_START;
					FN_TICK:  cmd.op = OP_TICK;
					default:  cmd.op = OP_FDATA;
				endcase
			end
			S_WALK: cmd.op = OP_WALK;
			default: cmd.op = OP_XFER;
		endcase
	end

	// State register and captured input word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			func_q  <= FN_READ;
			ra_q    <= 7'd0;
			wd_q    <= 8'd0;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) begin
					func_q  <= func;
					ra_q    <= reg_addr;
					wd_q    <= wdata;
					state_q <= S_EXEC;
				end
				S_EXEC, S_WALK, S_XFER: begin
					if (stat.xfer) state_q <= S_XFER;
					else if (stat.walking) state_q <= S_WALK;
					else state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/hdma_dp.sv]
module hdma_dp
	import hdma_pkg::*;
#(
	parameter int CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	output logic        done,
	output logic [2:0]  kind,
	output logic [7:0]  rdata,
	output logic        open_bus,
	output logic [23:0] a_address,
	output logic [7:0]  b_address,
	output logic        busy_res,
	output logic        final_item
);

	logic [7:0]  ctrl_q [8];
	logic [7:0]  badr_q [8];
	logic [7:0]  abank_q [8];
	logic [7:0]  ibank_q [8];
	logic [7:0]  spare_q [8];
	logic [15:0] aadr_q [8];
	logic [15:0] size_q [8];
	logic [15:0] tadr_q [8];
	logic [7:0]  rep_q [8];
	logic [7:0]  dact_q, hact_q, dox_q, term_q;
	logic [1:0]  offi_q [8];
	logic [9:0]  hst_q;
	logic [5:0]  dst_q;
	logic        drun_q;
	logic [1:0]  mode_q, wait_q;
	logic [3:0]  sch_q;
	logic [1:0]  xj_q;

	// Next-state copies, written by one combinational block.
	logic [7:0]  ctrl_d [8];
	logic [7:0]  badr_d [8];
	logic [7:0]  abank_d [8];
	logic [7:0]  ibank_d [8];
	logic [7:0]  spare_d [8];
	logic [15:0] aadr_d [8];
	logic [15:0] size_d [8];
	logic [15:0] tadr_d [8];
	logic [7:0]  rep_d [8];
	logic [7:0]  dact_d, hact_d, dox_d, term_d;
	logic [1:0]  offi_d [8];
	logic [9:0]  hst_d;
	logic [5:0]  dst_d;
	logic        drun_d;
	logic [1:0]  mode_d, wait_d;
	logic [3:0]  sch_d;
	logic [1:0]  xj_d;

	logic        e_v, e_ob, e_bz, e_fin;
	logic [2:0]  e_k;
	logic [7:0]  e_rd, e_b;
	logic [23:0] e_a;

	localparam logic [7:0] CH_MASK = 8'((9'd1 << CHANNELS) - 9'd1);

	function automatic logic [9:0] hadd(input logic [9:0] h, input logic [5:0] v);
		logic [10:0] s;
		s = {1'b0, h} + {5'd0, v};
		return (s > {1'b0, HDMA_MAX}) ? HDMA_MAX : s[9:0];
	endfunction

	function automatic logic [5:0] dadd(input logic [5:0] d, input logic [4:0] v);
		logic [6:0] s;
		s = {1'b0, d} + {2'd0, v};
		return (s > {1'b0, DMA_MAX}) ? DMA_MAX : s[5:0];
	endfunction

	// One step of the selected operation.
	always_comb begin
		logic [2:0] ch, c, m, fc;
		logic [3:0] r;
		logic       found, walk, xf;
		logic [7:0] nr;
		ctrl_d = ctrl_q; badr_d = badr_q; abank_d = abank_q; ibank_d = ibank_q;
		spare_d = spare_q; aadr_d = aadr_q; size_d = size_q; tadr_d = tadr_q;
		rep_d = rep_q; dact_d = dact_q; hact_d = hact_q; dox_d = dox_q;
		term_d = term_q; offi_d = offi_q; hst_d = hst_q; dst_d = dst_q;
		drun_d = drun_q; mode_d = mode_q; wait_d = wait_q; sch_d = sch_q; xj_d = xj_q;
		e_v = 1'b0; e_k = K_DONE; e_rd = 8'd0; e_ob = 1'b0; e_a = 24'd0; e_b = 8'd0;
		e_bz = 1'b0; e_fin = 1'b1;
		ch = cmd.ra[6:4]; r = cmd.ra[3:0];
		c = sch_q[2:0]; m = ctrl_q[c][2:0];
		found = 1'b0; fc = 3'd0; walk = 1'b0; xf = 1'b0; nr = 8'd0;
		unique case (cmd.op)
			OP_READ: begin
				e_v = 1'b1; e_k = K_READ;
				if ({1'b0, ch} >= 4'(CHANNELS) || r == 4'hc || r == 4'hd || r == 4'he)
					e_ob = 1'b1;
				else begin
					unique case (r)
						4'h0: e_rd = ctrl_q[ch];
						4'h1: e_rd = badr_q[ch];
						4'h2: e_rd = aadr_q[ch][7:0];
						4'h3: e_rd = aadr_q[ch][15:8];
						4'h4: e_rd = abank_q[ch];
						4'h5: e_rd = size_q[ch][7:0];
						4'h6: e_rd = size_q[ch][15:8];
						4'h7: e_rd = ibank_q[ch];
						4'h8: e_rd = tadr_q[ch][7:0];
						4'h9: e_rd = tadr_q[ch][15:8];
						4'ha: e_rd = rep_q[ch];
						default: e_rd = spare_q[ch];
					endcase
				end
			end
			OP_WRITE: begin
				e_v = 1'b1;
				if ({1'b0, ch} < 4'(CHANNELS)) begin
					unique case (r)
						4'h0: ctrl_d[ch] = cmd.wd;
						4'h1: badr_d[ch] = cmd.wd;
						4'h2: aadr_d[ch][7:0] = cmd.wd;
						4'h3: aadr_d[ch][15:8] = cmd.wd;
						4'h4: abank_d[ch] = cmd.wd;
						4'h5: size_d[ch][7:0] = cmd.wd;
						4'h6: size_d[ch][15:8] = cmd.wd;
						4'h7: ibank_d[ch] = cmd.wd;
						4'h8: tadr_d[ch][7:0] = cmd.wd;
						4'h9: tadr_d[ch][15:8] = cmd.wd;
						4'ha: rep_d[ch] = cmd.wd;
						4'hb, 4'hf: spare_d[ch] = cmd.wd;
						default: ;
					endcase
				end
			end
			OP_DMAEN: begin
				e_v = 1'b1;
				dact_d = cmd.wd & CH_MASK;
				drun_d = (cmd.wd & CH_MASK) != 8'd0;
				if ((cmd.wd & CH_MASK) != 8'd0) dst_d = dadd(dst_q, 5'd16);
			end
			OP_HDMEN: begin
				e_v = 1'b1;
				hact_d = cmd.wd & CH_MASK;
			end
			OP_START: begin
				if (mode_q != SM_IDLE) e_v = 1'b1;
				else begin
					hst_d = 10'd0;
					mode_d = (cmd.func == FN_INIT) ? SM_INIT : SM_LINE;
					sch_d = 4'd0; wait_d = W_NONE;
					walk = 1'b1;
				end
			end
			OP_TICK: begin
				e_v = 1'b1; e_bz = 1'b1;
				if (mode_q != SM_IDLE) e_bz = 1'b1;
				else if (hst_q != 10'd0)
					hst_d = (hst_q >= 10'd2) ? hst_q - 10'd2 : 10'd0;
				else if (!drun_q) e_bz = 1'b0;
				else if (dst_q != 6'd0)
					dst_d = (dst_q >= 6'd2) ? dst_q - 6'd2 : 6'd0;
				else begin
					for (int i = CHANNELS - 1; i >= 0; i--)
						if (dact_q[i]) begin
							found = 1'b1; fc = 3'(i);
						end
					if (!found) drun_d = 1'b0;
					else begin
						e_k = ctrl_q[fc][7] ? K_B2A : K_A2B;
						e_a = {abank_q[fc], aadr_q[fc]};
						e_b = badr_q[fc] + boff(ctrl_q[fc][2:0], offi_q[fc]);
						offi_d[fc] = offi_q[fc] + 2'd1;
						if (!ctrl_q[fc][3])
							aadr_d[fc] = aadr_q[fc] + (ctrl_q[fc][4] ? 16'hffff : 16'd1);
						size_d[fc] = size_q[fc] - 16'd1;
						if (size_q[fc] == 16'd1) begin
							offi_d[fc] = 2'd0; dact_d[fc] = 1'b0;
							dst_d = dadd(dst_q, 5'd14);
						end else dst_d = dadd(dst_q, 5'd6);
					end
				end
			end
			OP_FDATA: begin
				if (mode_q == SM_IDLE || wait_q == W_NONE || sch_q >= 4'(CHANNELS))
					e_v = 1'b1;
				else if (wait_q == W_REP && ctrl_q[c][6]) begin
					rep_d[c] = cmd.wd;
					hst_d = hadd(hst_q, 6'd16);
					e_v = 1'b1; e_k = K_FETCH;
					e_a = {abank_q[c], tadr_q[c]}; tadr_d[c] = tadr_q[c] + 16'd1;
					wait_d = W_LO;
				end else if (wait_q == W_LO) begin
					size_d[c] = {8'd0, cmd.wd};
					e_v = 1'b1; e_k = K_FETCH;
					e_a = {abank_q[c], tadr_q[c]}; tadr_d[c] = tadr_q[c] + 16'd1;
					wait_d = W_HI;
				end else begin
					if (wait_q == W_REP) begin
						rep_d[c] = cmd.wd; nr = cmd.wd;
					end else begin
						size_d[c][15:8] = size_q[c][15:8] | cmd.wd; nr = rep_q[c];
					end
					term_d[c] = (mode_q == SM_LINE) && nr == 8'd0;
					dox_d[c] = 1'b1;
					sch_d = sch_q + 4'd1; wait_d = W_NONE;
					walk = 1'b1;
				end
			end
			OP_XFER: begin
				// One HDMA copy per cycle.
				hst_d = hadd(hst_q, 6'd8);
				e_v = 1'b1; e_fin = 1'b0;
				e_k = ctrl_q[c][7] ? K_B2A : K_A2B;
				e_b = badr_q[c] + boff(m, xj_q);
				if (ctrl_q[c][6]) begin
					e_a = {ibank_q[c], size_q[c]}; size_d[c] = size_q[c] + 16'd1;
				end else begin
					e_a = {abank_q[c], tadr_q[c]}; tadr_d[c] = tadr_q[c] + 16'd1;
				end
				xj_d = xj_q + 2'd1;
				if ({1'b0, xj_q} == xlen_m1(m)) begin
					xf = 1'b0;
					nr = rep_q[c] - 8'd1;
					rep_d[c] = nr; dox_d[c] = nr[7];
					if (nr[6:0] == 7'd0) begin
						wait_d = W_REP;
						xf = 1'b1;
					end else begin
						sch_d = sch_q + 4'd1;
						walk = 1'b1;
					end
				end else xf = 1'b1;
			end
			OP_WALK: walk = 1'b1;
			default: ;
		endcase
		// Fetch after last copy of a line transfer: it is deferred to a walk step.
		stat.xfer = 1'b0;
		stat.walking = 1'b0;
		if (cmd.op == OP_XFER && xf && wait_d == W_REP && wait_q != W_REP) begin
			// last copy emitted; the fetch request follows as a walk-step
			e_v = 1'b1;
			stat.walking = 1'b1;
		end else if (cmd.op == OP_XFER && xf) begin
			stat.xfer = 1'b1;
		end else if (cmd.op == OP_XFER && walk) begin
			stat.walking = 1'b1;
		end else if (walk && !(cmd.op == OP_WALK && wait_q == W_REP)) begin
			// One channel of the walk per cycle while no copy run or fetch wait holds it.
			c = sch_d[2:0];
			if (sch_d >= 4'(CHANNELS)) begin
				if (hst_d != 10'd0) hst_d = hadd(hst_d, 6'd16);
				mode_d = SM_IDLE; sch_d = 4'd0; wait_d = W_NONE;
				e_v = 1'b1;
			end else if (mode_d == SM_INIT) begin
				if (hact_d[c]) begin
					dact_d[c] = 1'b0; offi_d[c] = 2'd0;
					e_v = 1'b1; e_k = K_FETCH;
					e_a = {abank_d[c], aadr_d[c]}; tadr_d[c] = aadr_d[c] + 16'd1;
					hst_d = hadd(hst_d, 6'd8);
					wait_d = W_REP;
				end else begin
					dox_d[c] = 1'b0; term_d[c] = 1'b0;
					sch_d = sch_d + 4'd1; stat.walking = 1'b1;
				end
			end else if (hact_d[c] && !term_d[c]) begin
				dact_d[c] = 1'b0; offi_d[c] = 2'd0;
				hst_d = hadd(hst_d, 6'd8);
				if (dox_d[c]) begin
					xj_d = 2'd0; stat.xfer = 1'b1;
				end else begin
					nr = rep_d[c] - 8'd1;
					rep_d[c] = nr; dox_d[c] = nr[7];
					if (nr[6:0] == 7'd0) begin
						e_v = 1'b1; e_k = K_FETCH;
						e_a = {abank_d[c], tadr_d[c]}; tadr_d[c] = tadr_d[c] + 16'd1;
						wait_d = W_REP;
					end else begin
						sch_d = sch_d + 4'd1; stat.walking = 1'b1;
					end
				end
			end else begin
				sch_d = sch_d + 4'd1; stat.walking = 1'b1;
			end
		end else if (cmd.op == OP_WALK) begin
			stat.walking = 1'b0;
		end
		// Pending fetch after a finished copy run.
		if (cmd.op == OP_WALK && wait_q == W_REP) begin
			stat.walking = 1'b0; stat.xfer = 1'b0;
			e_v = 1'b1; e_k = K_FETCH;
			e_a = {abank_q[c], tadr_q[c]}; tadr_d[c] = tadr_q[c] + 16'd1;
			ctrl_d = ctrl_q; hst_d = hst_q; sch_d = sch_q; mode_d = mode_q;
			wait_d = W_REP;
		end
		stat.emit = e_v;
	end

	assign done = e_v;

	// Unmapped channels keep their reset values forever.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				ctrl_q[i] <= 8'hff; badr_q[i] <= 8'hff; abank_q[i] <= 8'hff;
				ibank_q[i] <= 8'hff; spare_q[i] <= 8'hff; aadr_q[i] <= 16'hffff;
				size_q[i] <= 16'hffff; tadr_q[i] <= 16'hffff; rep_q[i] <= 8'hff;
				offi_q[i] <= 2'd0;
			end
			dact_q <= '0; hact_q <= '0; dox_q <= '0; term_q <= '0;
			hst_q <= '0; dst_q <= '0; drun_q <= 1'b0;
			mode_q <= SM_IDLE; wait_q <= W_NONE; sch_q <= '0; xj_q <= '0;
			kind <= K_DONE; rdata <= '0; open_bus <= 1'b0; a_address <= '0;
			b_address <= '0; busy_res <= 1'b0; final_item <= 1'b0;
		end else begin
			ctrl_q <= ctrl_d; badr_q <= badr_d; abank_q <= abank_d; ibank_q <= ibank_d;
			spare_q <= spare_d; aadr_q <= aadr_d; size_q <= size_d; tadr_q <= tadr_d;
			rep_q <= rep_d; offi_q <= offi_d;
			dact_q <= dact_d; hact_q <= hact_d; dox_q <= dox_d; term_q <= term_d;
			hst_q <= hst_d; dst_q <= dst_d; drun_q <= drun_d;
			mode_q <= mode_d; wait_q <= wait_d; sch_q <= sch_d; xj_q <= xj_d;
			kind <= e_k; rdata <= e_rd; open_bus <= e_ob; a_address <= e_a;
			b_address <= e_b; busy_res <= e_bz; final_item <= e_fin;
		end
	end

endmodule

[rtl/eight_channel_dma_hdma_controller.sv]
// The first result word is registered onto the outputs after the command is accepted;
// HDMA walks step through each channel visited, each copy and the closing word in
// turn, and a command holds busy until its last word is registered.
// Throughput: one command at a time; busy falls at the edge that registers the last
// word, so the next command may be accepted while that word is on the outputs.
// Results come with strobe for one cycle each and cannot be stalled.
// Reset (arst_n low) restores every channel register to all ones and clears all flags.
module eight_channel_dma_hdma_controller
	import hdma_pkg::*;
#(
	parameter int CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [6:0]  reg_addr,
	input  logic [7:0]  wdata,
	output logic        strobe,
	output logic [2:0]  kind,
	output logic [7:0]  rdata,
	output logic        open_bus,
	output logic [23:0] a_address,
	output logic [7:0]  b_address,
	output logic        busy_res,
	output logic        final_item
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     done;
	logic     ctl_busy;
	logic     strobe_q;

	hdma_ctrl u_ctrl (
		.clk, .arst_n, .start, .func, .reg_addr, .wdata,
		.stat, .cmd, .busy(ctl_busy)
	);

	hdma_dp #(.CHANNELS(CHANNELS)) u_dp (
		.clk, .arst_n, .cmd, .stat, .done,
		.kind, .rdata, .open_bus, .a_address, .b_address, .busy_res, .final_item
	);

	// Output strobe register, loaded from done at the same edge as the datapath's result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe_q <= 1'b0;
		else strobe_q <= done;
	end

	assign strobe = strobe_q;
	assign busy = ctl_busy;

	// Reads, fetch requests and done words always close their command.
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind == K_READ || kind == K_FETCH || kind == K_DONE) |-> final_item)
		else $error("closing word without final mark");
	// Busy rises once a command is accepted.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy did not rise");

endmodule
